/* rtl/weightless_ram_discriminator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the weightless RAM discriminator
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef WEIGHTLESS_RAM_DISCRIMINATOR_MACROS_SVH
`define WEIGHTLESS_RAM_DISCRIMINATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge, skipped while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif

`endif

/* rtl/wrd_pkg.sv */
// ----------------------------------------------------------------------------
// Weightless RAM discriminator package
// Sizes, derived widths and item kind codes shared by the block's files.
// ----------------------------------------------------------------------------
package wrd_pkg;

   // Geometry of the discriminator.
   localparam int PATCH_BITS = 25;
   localparam int TUPLE_BITS = 3;
   localparam int NUM_RAMS   = 8;

   // Fixed field widths of the interface.
   localparam int KIND_W   = 2;
   localparam int PATCH_W  = 25;
   localparam int PIX_W    = 5;
   localparam int THRESH_W = 9;
   localparam int HIT_OUT_W = 4;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd205;

   // Derived sizes.
   localparam int NUM_SLOTS = NUM_RAMS * TUPLE_BITS;
   localparam int ROW_W     = 2 ** TUPLE_BITS;
   localparam int ROW_AW    = (NUM_RAMS > 1) ? $clog2(NUM_RAMS) : 1;
   localparam int PERM_AW   = (PATCH_BITS > 1) ? $clog2(PATCH_BITS) : 1;
   localparam int CNT_MAX   = (NUM_SLOTS > PATCH_BITS) ? NUM_SLOTS : PATCH_BITS;
   localparam int CNT_W     = $clog2(CNT_MAX + 1);
   localparam int BIT_W     = (TUPLE_BITS > 1) ? $clog2(TUPLE_BITS) : 1;
   localparam int HIT_W     = $clog2(NUM_RAMS + 1);
   localparam int HIT_EXT_W = 7;
   localparam int CMP_W     = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_TRAIN   = 2'd0,
      KIND_PREDICT = 2'd1,
      KIND_CLEAR   = 2'd2,
      KIND_LOAD    = 2'd3
   } kind_type;

endpackage

/* rtl/weightless_ram_discriminator.sv */
// ----------------------------------------------------------------------------
// Weightless RAM discriminator
// Single-discriminator tuple-RAM classifier: trains, predicts, clears, loads.
// ----------------------------------------------------------------------------
// A predict's result is held in the result register until it is taken; a new
// result waits in the finishing state while the previous one is stalled.
// Train and predict requests stall the input channel until they are done;
// clear and load are done in the idle state. One permutation slot is fetched
// per cycle while a train or predict runs. Reset clears control state and
// every row valid bit; the permutation memory is not.
// ----------------------------------------------------------------------------
`include "weightless_ram_discriminator_macros.svh"

module weightless_ram_discriminator (
   input  logic                          clock,
   input  logic                          reset,
   // Input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wrd_pkg::KIND_W-1:0]    req_kind,
   input  logic [wrd_pkg::PATCH_W-1:0]   req_patch,
   input  logic [wrd_pkg::PIX_W-1:0]     req_perm_slot,
   input  logic [wrd_pkg::PIX_W-1:0]     req_perm_pixel,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_match,
   output logic [wrd_pkg::HIT_OUT_W-1:0] rsp_hit_count,
   // Configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wrd_pkg::THRESH_W-1:0]  csr_threshold_q8
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // The sequencer walks the permutation slots in order. Stage one fetches a
   // slot's pixel index from the permutation memory; when the data returns the
   // pixel is shifted into the tuple address, and on the last pixel of a tuple
   // the RAM row for that tuple is read. Stage two then either sets the
   // addressed bit (train) or counts it (predict). Each tuple touches its own
   // row, so rows in flight never collide and no forwarding is needed.

   state_type                      state_ff, state_in;
   wrd_pkg::kind_type              kind_ff, kind_in;
   logic [wrd_pkg::PATCH_W-1:0]    patch_ff, patch_in;
   logic [wrd_pkg::THRESH_W-1:0]   threshold_ff, threshold_in;

   // Issue side counters.
   logic [wrd_pkg::CNT_W-1:0]      slot_ff, slot_in;
   logic [wrd_pkg::BIT_W-1:0]      bit_ff, bit_in;
   logic [wrd_pkg::ROW_AW-1:0]     row_ff, row_in;

   // Stage one: permutation read in flight.
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_in_range_ff, s1_in_range_in;
   logic                           s1_last_bit_ff, s1_last_bit_in;
   logic                           s1_last_row_ff, s1_last_row_in;
   logic [wrd_pkg::ROW_AW-1:0]     s1_row_ff, s1_row_in;
   logic [wrd_pkg::TUPLE_BITS-1:0] addr_ff, addr_in;

   // Stage two: RAM row read in flight.
   logic                           s2_valid_ff, s2_valid_in;
   logic                           s2_last_row_ff, s2_last_row_in;
   logic [wrd_pkg::ROW_AW-1:0]     s2_row_ff, s2_row_in;
   logic [wrd_pkg::TUPLE_BITS-1:0] s2_addr_ff, s2_addr_in;

   logic [wrd_pkg::HIT_W-1:0]      hits_ff, hits_in;
   logic [wrd_pkg::NUM_RAMS-1:0]   row_valid_ff, row_valid_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_match_ff, rsp_match_in;
   logic [wrd_pkg::HIT_OUT_W-1:0]  rsp_hit_count_ff, rsp_hit_count_in;

   // Memory ports.
   logic                           perm_we, perm_re;
   logic [wrd_pkg::PERM_AW-1:0]    perm_waddr, perm_raddr;
   logic [wrd_pkg::PIX_W-1:0]      perm_rdata;
   logic                           row_we, row_re;
   logic [wrd_pkg::ROW_AW-1:0]     row_waddr, row_raddr;
   logic [wrd_pkg::ROW_W-1:0]      row_wdata, row_rdata, row_word;

   logic                           req_accept, out_free, pixel, row_bit;
   logic [wrd_pkg::TUPLE_BITS-1:0] full_addr;
   logic [wrd_pkg::HIT_EXT_W-1:0]  hits_ext;
   logic [wrd_pkg::CMP_W-1:0]      lhs, rhs;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // Pixel gathered for the slot returning from the permutation memory. Slots
   // past the permutation and stored indices past the patch both give a 0.
   assign pixel = s1_in_range_ff && (32'(perm_rdata) < wrd_pkg::PATCH_BITS) &&
                  patch_ff[perm_rdata];
   assign full_addr = wrd_pkg::TUPLE_BITS'({addr_ff, pixel});

   // A row that has not been written since reset or a clear reads as zero.
   assign row_word = row_valid_ff[s2_row_ff] ? row_rdata : '0;
   assign row_bit  = row_word[s2_addr_ff];

   // Match test: hits * 256 against threshold * NUM_RAMS.
   assign hits_ext = wrd_pkg::HIT_EXT_W'(hits_ff);
   assign lhs      = wrd_pkg::CMP_W'({hits_ext, 8'd0});
   assign rhs      = wrd_pkg::CMP_W'(threshold_ff) * wrd_pkg::CMP_W'(wrd_pkg::NUM_RAMS);

   always_comb begin
      state_in         = state_ff;
      kind_in          = kind_ff;
      patch_in         = patch_ff;
      threshold_in     = threshold_ff;
      slot_in          = slot_ff;
      bit_in           = bit_ff;
      row_in           = row_ff;
      s1_valid_in      = 1'b0;
      s1_in_range_in   = 1'b0;
      s1_last_bit_in   = 1'b0;
      s1_last_row_in   = 1'b0;
      s1_row_in        = row_ff;
      addr_in          = addr_ff;
      s2_valid_in      = 1'b0;
      s2_last_row_in   = 1'b0;
      s2_row_in        = s1_row_ff;
      s2_addr_in       = full_addr;
      hits_in          = hits_ff;
      row_valid_in     = row_valid_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_match_in     = rsp_match_ff;
      rsp_hit_count_in = rsp_hit_count_ff;

      perm_we    = 1'b0;
      perm_waddr = req_perm_slot[wrd_pkg::PERM_AW-1:0];
      perm_re    = 1'b0;
      perm_raddr = slot_ff[wrd_pkg::PERM_AW-1:0];
      row_we     = 1'b0;
      row_waddr  = s2_row_ff;
      row_wdata  = row_word | (wrd_pkg::ROW_W'(1) << s2_addr_ff);
      row_re     = 1'b0;
      row_raddr  = s1_row_ff;

      if (csr_valid && csr_ready) begin
         threshold_in = csr_threshold_q8;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (wrd_pkg::kind_type'(req_kind))
                  wrd_pkg::KIND_CLEAR: begin
                     row_valid_in = '0;
                  end
                  wrd_pkg::KIND_LOAD: begin
                     perm_we = (32'(req_perm_slot) < wrd_pkg::PATCH_BITS);
                  end
                  wrd_pkg::KIND_TRAIN, wrd_pkg::KIND_PREDICT: begin
                     kind_in  = wrd_pkg::kind_type'(req_kind);
                     patch_in = req_patch;
                     slot_in  = '0;
                     bit_in   = '0;
                     row_in   = '0;
                     addr_in  = '0;
                     hits_in  = '0;
                     state_in = ST_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            // Issue: one permutation slot per cycle.
            if (32'(slot_ff) < wrd_pkg::NUM_SLOTS) begin
               perm_re        = (32'(slot_ff) < wrd_pkg::PATCH_BITS);
               s1_valid_in    = 1'b1;
               s1_in_range_in = perm_re;
               s1_last_bit_in = (32'(bit_ff) == wrd_pkg::TUPLE_BITS - 1);
               s1_last_row_in = (32'(row_ff) == wrd_pkg::NUM_RAMS - 1);
               slot_in        = slot_ff + 1'b1;
               if (s1_last_bit_in) begin
                  bit_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  bit_in = bit_ff + 1'b1;
               end
            end
            // Stage one: build the tuple address, read its row when complete.
            if (s1_valid_ff) begin
               if (s1_last_bit_ff) begin
                  addr_in        = '0;
                  row_re         = 1'b1;
                  s2_valid_in    = 1'b1;
                  s2_last_row_in = s1_last_row_ff;
               end else begin
                  addr_in = full_addr;
               end
            end
            // Stage two: set or count the addressed bit.
            if (s2_valid_ff) begin
               if (kind_ff == wrd_pkg::KIND_TRAIN) begin
                  row_we                  = 1'b1;
                  row_valid_in[s2_row_ff] = 1'b1;
               end else begin
                  hits_in = hits_ff + wrd_pkg::HIT_W'(row_bit);
               end
               if (s2_last_row_ff) begin
                  state_in = (kind_ff == wrd_pkg::KIND_TRAIN) ? ST_IDLE : ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_match_in     = (lhs > rhs);
               rsp_hit_count_in = (hits_ext > wrd_pkg::HIT_EXT_W'(15)) ?
                                  wrd_pkg::HIT_OUT_W'(15) :
                                  hits_ext[wrd_pkg::HIT_OUT_W-1:0];
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         threshold_ff <= wrd_pkg::THRESH_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hits_ff      <= hits_in;
      end
      kind_ff          <= kind_in;
      patch_ff         <= patch_in;
      slot_ff          <= slot_in;
      bit_ff           <= bit_in;
      row_ff           <= row_in;
      s1_in_range_ff   <= s1_in_range_in;
      s1_last_bit_ff   <= s1_last_bit_in;
      s1_last_row_ff   <= s1_last_row_in;
      s1_row_ff        <= s1_row_in;
      addr_ff          <= addr_in;
      s2_last_row_ff   <= s2_last_row_in;
      s2_row_ff        <= s2_row_in;
      s2_addr_ff       <= s2_addr_in;
      rsp_match_ff     <= rsp_match_in;
      rsp_hit_count_ff <= rsp_hit_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_match     = rsp_match_ff;
   assign rsp_hit_count = rsp_hit_count_ff;

   // Permutation memory: one pixel index per slot.
   wrd_ram #(
      .WIDTH (wrd_pkg::PIX_W),
      .DEPTH (wrd_pkg::PATCH_BITS)
   ) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_we),
      .wr_addr (perm_waddr),
      .wr_data (req_perm_pixel),
      .rd_en   (perm_re),
      .rd_addr (perm_raddr),
      .rd_data (perm_rdata)
   );

   // Tuple RAMs: one row per RAM, one bit per tuple address.
   wrd_ram #(
      .WIDTH (wrd_pkg::ROW_W),
      .DEPTH (wrd_pkg::NUM_RAMS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_en   (row_re),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   // The hit counter can never run past the number of RAMs.
   `ASSERT_CLK_RST(a_hits_bounded, clock, reset,
      32'(hits_ff) <= wrd_pkg::NUM_RAMS, "hit counter exceeds the number of RAMs")
   // By the time the result is formed the pipeline has drained.
   `ASSERT_CLK_RST(a_finish_drained, clock, reset,
      state_ff == ST_FINISH |-> !s1_valid_ff && !s2_valid_ff,
      "pipeline still busy when the result is formed")
   // A new result only ever comes from the finishing state.
   `ASSERT_CLK_RST(a_result_source, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH,
      "result raised outside the finishing state")

endmodule

/* rtl/wrd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
